### hw/rtl/iorb_pkg.sv
// Shared types and constants for the in-order release buffer.
package iorb_pkg;

  // Slot count of the reorder window (2..64).
  localparam int Window = 32;
  localparam int IdxW   = (Window > 1) ? $clog2(Window) : 1;
  localparam int CntW   = $clog2(Window + 1);

  localparam logic [1:0] CmdGrant = 2'd0;
  localparam logic [1:0] CmdPush  = 2'd1;
  localparam logic [1:0] CmdDrop  = 2'd2;

  localparam logic [1:0] KindGrant   = 2'd0;
  localparam logic [1:0] KindDeliver = 2'd1;
  localparam logic [1:0] KindReject  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] seq_id;
    logic [31:0] receiver_handle;
    logic [31:0] content_handle;
  } iorb_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] out_seq_id;
    logic [31:0] out_receiver;
    logic [31:0] out_content;
    logic        last;
  } iorb_out_t;

  typedef struct packed {
    logic [31:0] receiver;
    logic [31:0] content;
  } iorb_slot_t;

endpackage

### hw/rtl/in_order_release_buffer_core.sv
// In-order release buffer: grants sequence numbers and releases messages in number order.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+---------------------------
//   in      | in  | in_valid_i / in_ready_o | in_data_i  (iorb_in_t)
//   out     | out | out_valid_o/out_ready_i | out_data_o (iorb_out_t)
//
// A grant, reject or parked push is accepted in idle, then checked in the window unit.
// A push that reaches the head walks the run of parked slots behind it, releasing each in turn,
// then ends the walk and flushes the final result; each step reads a slot RAM entry, then evaluates it.
// Reset clears the counters and all slot valid bits at once; no clearing pass is needed.
// A stalled output holds the sequencer wherever it has a result to hand over.
module in_order_release_buffer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  iorb_pkg::iorb_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output iorb_pkg::iorb_out_t out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StWalkRd = 3'd2;
  localparam logic [2:0] StWalkEv = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  logic [2:0] state_q, state_d;
  iorb_pkg::iorb_in_t  in_q, in_d;
  logic [63:0] next_q, next_d;
  logic [63:0] head_q, head_d;
  logic [iorb_pkg::IdxW-1:0] hidx_q, hidx_d;
  logic [iorb_pkg::CntW-1:0] occ_q, occ_d;
  logic [iorb_pkg::Window-1:0] slot_valid_q, slot_valid_d;
  iorb_pkg::iorb_out_t pend_q, pend_d;
  logic pend_valid_q, pend_valid_d;
  iorb_pkg::iorb_out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  iorb_pkg::iorb_slot_t slot_mem [iorb_pkg::Window];
  iorb_pkg::iorb_slot_t rd_q;
  logic mem_we, rd_en;

  logic        out_free;
  logic [63:0] diff;
  logic        in_range;
  logic [31:0] eff_rcv, eff_cnt;
  logic [iorb_pkg::IdxW:0]   idx_sum;
  logic [iorb_pkg::IdxW-1:0] seq_idx;
  logic [iorb_pkg::IdxW-1:0] hidx_inc;

  function automatic iorb_pkg::iorb_out_t mk_out(logic [1:0] kind, logic [63:0] seq,
                                                 logic [31:0] rcv, logic [31:0] cnt,
                                                 logic lst);
    iorb_pkg::iorb_out_t r;
    r.kind         = kind;
    r.out_seq_id   = seq;
    r.out_receiver = rcv;
    r.out_content  = cnt;
    r.last         = lst;
    return r;
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign diff      = in_q.seq_id - head_q;
  assign in_range  = (diff[63:iorb_pkg::CntW] == '0) && (diff[iorb_pkg::CntW-1:0] < occ_q);
  assign eff_rcv   = (in_q.cmd == iorb_pkg::CmdDrop) ? 32'd0 : in_q.receiver_handle;
  assign eff_cnt   = (in_q.cmd == iorb_pkg::CmdDrop) ? 32'd0 : in_q.content_handle;
  // Slot of seq is head slot plus distance, wrapped once: distance stays below Window.
  assign idx_sum   = {1'b0, hidx_q} + {1'b0, diff[iorb_pkg::IdxW-1:0]};
  assign seq_idx   = (idx_sum >= (iorb_pkg::IdxW+1)'(iorb_pkg::Window))
                   ? iorb_pkg::IdxW'(idx_sum - (iorb_pkg::IdxW+1)'(iorb_pkg::Window))
                   : idx_sum[iorb_pkg::IdxW-1:0];
  assign hidx_inc  = (hidx_q == iorb_pkg::IdxW'(iorb_pkg::Window - 1))
                   ? '0 : hidx_q + 1'b1;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    next_d       = next_q;
    head_d       = head_q;
    hidx_d       = hidx_q;
    occ_d        = occ_q;
    slot_valid_d = slot_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    rd_en        = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = StCheck;
        end
      end
      StCheck: begin
        case (in_q.cmd)
          iorb_pkg::CmdGrant: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              if (occ_q >= iorb_pkg::CntW'(iorb_pkg::Window)) begin
                out_d = mk_out(iorb_pkg::KindReject, 64'd0, 32'd0, 32'd0, 1'b1);
              end else begin
                out_d  = mk_out(iorb_pkg::KindGrant, next_q, 32'd0, 32'd0, 1'b1);
                next_d = next_q + 64'd1;
                occ_d  = occ_q + 1'b1;
              end
              state_d = StIdle;
            end
          end
          iorb_pkg::CmdPush, iorb_pkg::CmdDrop: begin
            if (!in_range) begin
              if (out_free) begin
                out_valid_d = 1'b1;
                out_d = mk_out(iorb_pkg::KindReject, in_q.seq_id, 32'd0, 32'd0, 1'b1);
                state_d = StIdle;
              end
            end else if (in_q.seq_id != head_q) begin
              // park out-of-order entry
              mem_we                = 1'b1;
              slot_valid_d[seq_idx] = 1'b1;
              state_d               = StIdle;
            end else begin
              if (eff_rcv != 32'd0) begin
                pend_d       = mk_out(iorb_pkg::KindDeliver, head_q, eff_rcv, eff_cnt, 1'b0);
                pend_valid_d = 1'b1;
              end
              head_d  = head_q + 64'd1;
              hidx_d  = hidx_inc;
              occ_d   = occ_q - 1'b1;
              state_d = StWalkRd;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = mk_out(iorb_pkg::KindReject, 64'd0, 32'd0, 32'd0, 1'b1);
              state_d = StIdle;
            end
          end
        endcase
      end
      StWalkRd: begin
        if (occ_q != '0 && slot_valid_q[hidx_q]) begin
          rd_en                = 1'b1;
          slot_valid_d[hidx_q] = 1'b0;
          state_d              = StWalkEv;
        end else begin
          state_d = StFlush;
        end
      end
      StWalkEv: begin
        if (rd_q.receiver == 32'd0) begin
          head_d  = head_q + 64'd1;
          hidx_d  = hidx_inc;
          occ_d   = occ_q - 1'b1;
          state_d = StWalkRd;
        end else if (!pend_valid_q || out_free) begin
          // a newer delivery exists, so the held one is not the last
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_d       = mk_out(iorb_pkg::KindDeliver, head_q, rd_q.receiver, rd_q.content,
                                1'b0);
          pend_valid_d = 1'b1;
          head_d       = head_q + 64'd1;
          hidx_d       = hidx_inc;
          occ_d        = occ_q - 1'b1;
          state_d      = StWalkRd;
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      next_q       <= '0;
      head_q       <= '0;
      hidx_q       <= '0;
      occ_q        <= '0;
      slot_valid_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_q       <= next_d;
      head_q       <= head_d;
      hidx_q       <= hidx_d;
      occ_q        <= occ_d;
      slot_valid_q <= slot_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[seq_idx] <= '{receiver: eff_rcv, content: eff_cnt};
    end
    if (rd_en) begin
      rd_q <= slot_mem[hidx_q];
    end
  end

  // Outstanding count never exceeds the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= iorb_pkg::CntW'(iorb_pkg::Window))
    else $error("outstanding count above window");

  // The number of parked entries never exceeds the outstanding count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_valid_q) <= int'(occ_q))
    else $error("more parked slots than outstanding numbers");

  // Nothing is left pending once the sequencer is back in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("pending delivery lost at idle");

  // A delivery always carries a receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == iorb_pkg::KindDeliver) |-> (out_q.out_receiver != 32'd0))
    else $error("delivery with zero receiver");

endmodule
